// ===== hdl/assert_macros.svh =====
// assertion macros shared by the escape decoder rtl
// no dependencies; included by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define JSE_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define JSE_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/jse_pkg.sv =====
// types, codes and helper functions of the json string escape decoder
// no dependencies
`default_nettype none

package jse_pkg;

  localparam int CH_W     = 21;
  localparam int UNIT_W   = 16;
  localparam int STATUS_W = 2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_LETTER = 2'd1;
  localparam logic [STATUS_W-1:0] ST_HEX    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NO_U   = 2'd3;

  // characters of interest
  localparam logic [CH_W-1:0] CH_SLASH  = 21'h2F;
  localparam logic [CH_W-1:0] CH_QUOTE  = 21'h22;
  localparam logic [CH_W-1:0] CH_BSLASH = 21'h5C;
  localparam logic [CH_W-1:0] CH_B      = 21'h62;
  localparam logic [CH_W-1:0] CH_F      = 21'h66;
  localparam logic [CH_W-1:0] CH_N      = 21'h6E;
  localparam logic [CH_W-1:0] CH_R      = 21'h72;
  localparam logic [CH_W-1:0] CH_T      = 21'h74;
  localparam logic [CH_W-1:0] CH_U      = 21'h75;

  // surrogate detection
  localparam logic [UNIT_W-1:0] SURR_MASK = 16'hFC00;
  localparam logic [UNIT_W-1:0] SURR_HIGH = 16'hD800;

  typedef struct packed {
    logic [CH_W-1:0]     code_point;
    logic [STATUS_W-1:0] status;
    logic                char_returned;
    logic                has_char;
  } res_t;

  // returns {digit_ok, digit_value}
  function automatic logic [4:0] hex_decode(input logic [CH_W-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 21'h30 && c <= 21'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 21'h41 && c <= 21'h46) || (c >= 21'h61 && c <= 21'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/jse_if.sv =====
// valid/ready channel interfaces for the escape decoder input and result
// depends on jse_pkg
`default_nettype none

interface jse_in_if;
  import jse_pkg::*;
  logic            valid;
  logic            ready;
  logic            start_req;
  logic [CH_W-1:0] ch;

  modport source (output valid, output start_req, output ch, input ready);
  modport sink   (input valid, input start_req, input ch, output ready);
endinterface

interface jse_out_if;
  import jse_pkg::*;
  logic                valid;
  logic                ready;
  logic [CH_W-1:0]     code_point;
  logic [STATUS_W-1:0] status;
  logic                char_returned;
  logic                has_char;

  modport source (output valid, output code_point, output status,
                  output char_returned, output has_char, input ready);
  modport sink   (input valid, input code_point, input status,
                  input char_returned, input has_char, output ready);
endinterface

`default_nettype wire

// ===== hdl/jse_core.sv =====
// escape state machine: phase, hex digit count and utf-16 units
// depends on jse_pkg and assert_macros.svh
`default_nettype none

module jse_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  logic                  start_req,
  input  logic [jse_pkg::CH_W-1:0] ch,
  output logic                  res_valid,
  output jse_pkg::res_t         res
);
  import jse_pkg::*;
  `include "assert_macros.svh"

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_HEX1 = 3'd1;
  localparam logic [2:0] PH_BSL  = 3'd2;
  localparam logic [2:0] PH_U    = 3'd3;
  localparam logic [2:0] PH_HEX2 = 3'd4;

  logic [2:0]        phase_r, phase_nxt;
  logic [1:0]        digit_cnt_r, digit_cnt_nxt;
  logic [UNIT_W-1:0] high_unit_r, high_unit_nxt;
  logic [UNIT_W-1:0] low_unit_r, low_unit_nxt;
  logic [4:0]        hex;
  logic [UNIT_W-1:0] high_shift, low_shift;

  assign hex        = hex_decode(ch);
  assign high_shift = {high_unit_r[UNIT_W-5:0], hex[3:0]};
  assign low_shift  = {low_unit_r[UNIT_W-5:0], hex[3:0]};

  always_comb begin
    phase_nxt     = phase_r;
    digit_cnt_nxt = digit_cnt_r;
    high_unit_nxt = high_unit_r;
    low_unit_nxt  = low_unit_r;
    res_valid     = 1'b0;
    res           = '0;
    if (start_req) begin
      phase_nxt    = PH_IDLE;
      res_valid    = 1'b1;
      res.has_char = 1'b1;
      res.status   = ST_OK;
      unique case (ch)
        CH_SLASH:  res.code_point = CH_SLASH;
        CH_QUOTE:  res.code_point = CH_QUOTE;
        CH_BSLASH: res.code_point = CH_BSLASH;
        CH_B:      res.code_point = 21'h08;
        CH_F:      res.code_point = 21'h0C;
        CH_N:      res.code_point = 21'h0A;
        CH_R:      res.code_point = 21'h0D;
        CH_T:      res.code_point = 21'h09;
        CH_U: begin
          phase_nxt     = PH_HEX1;
          digit_cnt_nxt = 2'd0;
          high_unit_nxt = '0;
          res_valid     = 1'b0;
          res           = '0;
        end
        default: begin
          res.has_char = 1'b0;
          res.status   = ST_LETTER;
        end
      endcase
    end else begin
      unique case (phase_r)
        PH_HEX1, PH_HEX2: begin
          if (!hex[4]) begin
            phase_nxt     = PH_IDLE;
            digit_cnt_nxt = 2'd0;
            res_valid     = 1'b1;
            res.status    = ST_HEX;
          end else begin
            if (phase_r == PH_HEX1) begin
              high_unit_nxt = high_shift;
            end else begin
              low_unit_nxt = low_shift;
            end
            if (digit_cnt_r != 2'd3) begin
              digit_cnt_nxt = digit_cnt_r + 2'd1;
            end else begin
              digit_cnt_nxt = 2'd0;
              phase_nxt     = PH_IDLE;
              if (phase_r == PH_HEX1) begin
                if ((high_shift & SURR_MASK) == SURR_HIGH) begin
                  phase_nxt = PH_BSL;
                end else begin
                  res_valid      = 1'b1;
                  res.code_point = {5'd0, high_shift};
                  res.has_char   = 1'b1;
                end
              end else begin
                // join the surrogate pair into one code point
                res_valid      = 1'b1;
                res.code_point = {({1'b0, high_unit_r[9:6]} + 5'd1), high_unit_r[5:0],
                                  low_shift[9:0]};
                res.has_char   = 1'b1;
              end
            end
          end
        end
        PH_BSL, PH_U: begin
          if ((phase_r == PH_BSL && ch == CH_BSLASH)) begin
            phase_nxt = PH_U;
          end else if (phase_r == PH_U && ch == CH_U) begin
            phase_nxt     = PH_HEX2;
            digit_cnt_nxt = 2'd0;
            low_unit_nxt  = '0;
          end else begin
            // lone high surrogate, character goes back
            phase_nxt         = PH_IDLE;
            res_valid         = 1'b1;
            res.code_point    = {5'd0, high_unit_r};
            res.status        = ST_NO_U;
            res.char_returned = 1'b1;
            res.has_char      = 1'b1;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      digit_cnt_r <= 2'd0;
      high_unit_r <= '0;
      low_unit_r  <= '0;
    end else if (step_en) begin
      phase_r     <= phase_nxt;
      digit_cnt_r <= digit_cnt_nxt;
      high_unit_r <= high_unit_nxt;
      low_unit_r  <= low_unit_nxt;
    end
  end

  `JSE_ASSERT_IMP(a_pair_holds_high, clk, rst_n,
    phase_r == PH_BSL || phase_r == PH_U || phase_r == PH_HEX2,
    (high_unit_r & SURR_MASK) == SURR_HIGH, "pair phase without a high surrogate")
  `JSE_ASSERT_IMP(a_cnt_clear_in_pair, clk, rst_n,
    phase_r == PH_BSL || phase_r == PH_U, digit_cnt_r == 2'd0,
    "digit count left over while waiting for backslash or u")
  `JSE_ASSERT_NXT(a_idle_hold, clk, rst_n, !step_en,
    $stable(phase_r) && $stable(high_unit_r), "state moved without a step")

endmodule

`default_nettype wire

// ===== hdl/json_string_escape_decoder.sv =====
// json string escape decoder: ordinary characters after a backslash in, code points out
// simple, \uXXXX and surrogate pair escapes
// this file holds the top level; depends on jse_pkg, jse_if, jse_core, assert_macros.svh
//
// usage
//   in_chan  : one character per transaction; start_req marks the escape letter
//              right after the opening backslash
//   out_chan : zero or one result per input transaction (code_point, status,
//              char_returned, has_char)
//   path     : an input transaction is held in the input register, and its result
//              is then loaded into the result register, from which it is taken
//   rate     : one transaction per cycle while out_chan is not held; the escape state is
//              updated between the input register and the result register
//   reset    : synchronous active-low rst_n empties both registers and puts the
//              escape state back to idle with all units zero
//   stall    : while out_chan is held, a finished result waits in the result
//              register and one more character is held in the input register;
//              in_chan.ready drops only when both are full and out_chan.ready is low
`default_nettype none

module json_string_escape_decoder (
  input  logic      clk,
  input  logic      rst_n,
  jse_in_if.sink    in_chan,
  jse_out_if.source out_chan
);
  import jse_pkg::*;
  `include "assert_macros.svh"

  // input register
  logic            in_valid_r, in_valid_nxt;
  logic            in_start_r;
  logic [CH_W-1:0] in_ch_r;

  // result register
  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;

  logic in_take;     // input transaction accepted this cycle
  logic adv;         // held character steps the state machine this cycle
  logic core_valid;  // step produces a result
  res_t core_res;

  // the held character moves once the result register is free or being drained
  assign adv     = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_take = in_chan.valid && in_chan.ready;

  assign in_chan.ready = !in_valid_r || adv;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (adv) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = core_valid;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_start_r <= in_chan.start_req;
      in_ch_r    <= in_chan.ch;
    end
    if (adv && core_valid) begin
      out_res_r <= core_res;
    end
  end

  jse_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (adv),
    .start_req (in_start_r),
    .ch        (in_ch_r),
    .res_valid (core_valid),
    .res       (core_res)
  );

  assign out_chan.valid         = out_valid_r;
  assign out_chan.code_point    = out_res_r.code_point;
  assign out_chan.status        = out_res_r.status;
  assign out_chan.char_returned = out_res_r.char_returned;
  assign out_chan.has_char      = out_res_r.has_char;

  `JSE_ASSERT_IMP(a_ret_is_no_u, clk, rst_n, out_valid_r && out_res_r.char_returned,
    out_res_r.status == ST_NO_U && out_res_r.has_char,
    "returned char without missing u status")
  `JSE_ASSERT_IMP(a_empty_is_zero, clk, rst_n, out_valid_r && !out_res_r.has_char,
    out_res_r.code_point == '0, "code point set without a char")
  `JSE_ASSERT_NXT(a_hold_input, clk, rst_n, in_valid_r && !adv,
    in_valid_r && $stable(in_ch_r), "held character lost")

endmodule

`default_nettype wire
